FILE: hdl/wuf_pkg.sv
// Shared types and action codes for the weighted union-find block.
package wuf_pkg;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_UNITE = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	localparam int NODE_FIELD_W = 10;
	localparam int SIZE_FIELD_W = 11;
	localparam int ITEM_WT_W    = 32;
	localparam int SUM_W        = 42;

	typedef struct packed {
		action_t                   action;
		logic [NODE_FIELD_W-1:0]   node_a;
		logic [NODE_FIELD_W-1:0]   node_b;
		logic [ITEM_WT_W-1:0]      node_weight;
	} item_t;

	typedef struct packed {
		logic [NODE_FIELD_W-1:0]   root_of_a;
		logic                      same_set;
		logic [SIZE_FIELD_W-1:0]   set_size;
		logic [NODE_FIELD_W-1:0]   set_min;
		logic [NODE_FIELD_W-1:0]   set_max;
		logic [SUM_W-1:0]          set_weight;
	} result_t;

endpackage

FILE: hdl/wuf_ram.sv
// Simple dual-port RAM: one write port, one registered read port with enable.
module wuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/weighted_union_find_core.sv
// Weighted union-find core: disjoint-set forest with union by size and path compression.
// A query or load finds the roots of a and b, walking each path and then compressing it; a unite
// also merges the two sets unless a and b already share one, and a clear sweeps the node memory
// before its report. A non-power-of-two NODES below 1024 adds a reduction of the node indices.
// One item is in work at a time, so the next beat is taken only after the result is registered.
// After reset a sweep initializes both memories while the input is stalled.
module weighted_union_find_core import wuf_pkg::*; #(
	parameter int NODES = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int IW = $clog2(NODES);
	localparam int SW = IW + 1;
	localparam bit POW2 = (NODES & (NODES - 1)) == 0;
	localparam bit NEED_RED = (NODES < 1024) && !POW2;
	localparam logic [IW-1:0] LAST = IW'(NODES - 1);

	// One node entry: the parent link, and the set summary that is meaningful at a root.
	typedef struct packed {
		logic [IW-1:0] parent;
		logic [SW-1:0] size;
		logic [IW-1:0] min_idx;
		logic [IW-1:0] max_idx;
	} node_t;

	localparam int NW = $bits(node_t);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_RED, S_ACT, S_CLR, S_FSTART, S_FWALK, S_CWALK,
		S_U0, S_U1, S_U2, S_U3, S_REP, S_REP2
	} state_t;

	state_t state_q;

	// Item registers. The node fields are reduced in place when NODES needs it.
	action_t                 act_q;
	logic [NODE_FIELD_W-1:0] a_q, b_q;
	logic [ITEM_WT_W-1:0]    wt_q;
	logic [3:0]              rk_q;

	// Find walker: which_q picks node a or b, phase_q set means the finds feed the report.
	logic          which_q, phase_q;
	logic [IW-1:0] cur_q, root_q, ra_q, rb_q, cnt_q;

	// Unite scratch.
	node_t             na_q, nwn_q;
	logic [SUM_W-1:0]  wa_q, nwt_q;
	logic [IW-1:0]     win_q;

	logic              result_valid_q;
	result_t           result_q;

	// Memory ports.
	logic              n_we, n_re, w_we, w_re;
	logic [IW-1:0]     n_waddr, n_raddr, w_waddr, w_raddr;
	node_t             n_wdata, n_rd;
	logic [NW-1:0]     n_rd_bits;
	logic [SUM_W-1:0]  w_wdata, w_rd;

	logic [IW-1:0]     ia, ib, start;
	logic [26:0]       thr;
	logic              swap;
	logic [IW-1:0]     win, lose;
	node_t             lose_n;

	assign ia = IW'(a_q);
	assign ib = IW'(b_q);
	assign start = which_q ? ib : ia;
	assign n_rd = node_t'(n_rd_bits);
	assign thr = 27'(NODES) << rk_q;

	// Union by size; on equal sizes the root of a's set stays the root.
	assign swap = na_q.size < n_rd.size;
	assign win = swap ? rb_q : ra_q;
	assign lose = swap ? ra_q : rb_q;
	assign lose_n = swap ? na_q : n_rd;

	assign item_stall = state_q != S_IDLE;
	assign result_valid = result_valid_q;
	assign result = result_q;

	wuf_ram #(.WIDTH(NW), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.re    (n_re),
		.raddr (n_raddr),
		.rdata (n_rd_bits)
	);

	wuf_ram #(.WIDTH(SUM_W), .DEPTH(NODES)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.re    (w_re),
		.raddr (w_raddr),
		.rdata (w_rd)
	);

	// Memory port control follows the sequencer state. Reads issued here return next cycle.
	always_comb begin
		n_we = 1'b0;
		n_waddr = cnt_q;
		n_wdata = '{parent: cnt_q, size: SW'(1), min_idx: cnt_q, max_idx: cnt_q};
		n_re = 1'b0;
		n_raddr = start;
		w_we = 1'b0;
		w_waddr = cnt_q;
		w_wdata = '0;
		w_re = 1'b0;
		w_raddr = ra_q;
		case (state_q)
			S_INIT: begin
				n_we = 1'b1;
				w_we = 1'b1;
			end
			S_CLR: begin
				n_we = 1'b1;
			end
			S_ACT: begin
				if (act_q == ACT_LOAD) begin
					w_we = 1'b1;
					w_waddr = ia;
					w_wdata = SUM_W'(wt_q);
				end
			end
			S_FSTART: begin
				n_re = 1'b1;
				n_raddr = start;
			end
			S_FWALK: begin
				if (n_rd.parent != cur_q) begin
					n_re = 1'b1;
					n_raddr = n_rd.parent;
				end else if (start != cur_q) begin
					n_re = 1'b1;
					n_raddr = start;
				end
			end
			S_CWALK: begin
				// Point this node straight at the root and fetch the next one up.
				n_we = 1'b1;
				n_waddr = cur_q;
				n_wdata = n_rd;
				n_wdata.parent = root_q;
				if (n_rd.parent != root_q) begin
					n_re = 1'b1;
					n_raddr = n_rd.parent;
				end
			end
			S_U0: begin
				if (ra_q != rb_q) begin
					n_re = 1'b1;
					n_raddr = ra_q;
					w_re = 1'b1;
					w_raddr = ra_q;
				end
			end
			S_U1: begin
				n_re = 1'b1;
				n_raddr = rb_q;
				w_re = 1'b1;
				w_raddr = rb_q;
			end
			S_U2: begin
				n_we = 1'b1;
				n_waddr = lose;
				n_wdata = lose_n;
				n_wdata.parent = win;
			end
			S_U3: begin
				n_we = 1'b1;
				n_waddr = win_q;
				n_wdata = nwn_q;
				w_we = 1'b1;
				w_waddr = win_q;
				w_wdata = nwt_q;
			end
			S_REP: begin
				n_re = 1'b1;
				n_raddr = ra_q;
				w_re = 1'b1;
				w_raddr = ra_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: one item at a time, result parked in the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// The report state handles its own valid, including a beat taken in that cycle.
			if (result_valid_q && !result_stall && state_q != S_REP2) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						act_q <= item.action;
						a_q <= item.node_a;
						b_q <= item.node_b;
						wt_q <= item.node_weight;
						rk_q <= 4'd9;
						state_q <= NEED_RED ? S_RED : S_ACT;
					end
				end
				S_RED: begin
					// Restoring reduction modulo NODES, one shifted multiple per cycle.
					if (27'(a_q) >= thr) begin
						a_q <= a_q - thr[NODE_FIELD_W-1:0];
					end
					if (27'(b_q) >= thr) begin
						b_q <= b_q - thr[NODE_FIELD_W-1:0];
					end
					rk_q <= rk_q - 1'b1;
					if (rk_q == 4'd0) begin
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					which_q <= 1'b0;
					phase_q <= act_q != ACT_UNITE;
					cnt_q <= '0;
					state_q <= (act_q == ACT_CLEAR) ? S_CLR : S_FSTART;
				end
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						ra_q <= ia;
						rb_q <= ib;
						state_q <= S_REP;
					end
				end
				S_FSTART: begin
					cur_q <= start;
					state_q <= S_FWALK;
				end
				S_FWALK: begin
					if (n_rd.parent != cur_q) begin
						cur_q <= n_rd.parent;
					end else if (start != cur_q) begin
						root_q <= cur_q;
						cur_q <= start;
						state_q <= S_CWALK;
					end else if (!which_q) begin
						ra_q <= cur_q;
						which_q <= 1'b1;
						state_q <= S_FSTART;
					end else begin
						rb_q <= cur_q;
						state_q <= phase_q ? S_REP : S_U0;
					end
				end
				S_CWALK: begin
					if (n_rd.parent != root_q) begin
						cur_q <= n_rd.parent;
					end else if (!which_q) begin
						ra_q <= root_q;
						which_q <= 1'b1;
						state_q <= S_FSTART;
					end else begin
						rb_q <= root_q;
						state_q <= phase_q ? S_REP : S_U0;
					end
				end
				S_U0: begin
					state_q <= (ra_q == rb_q) ? S_REP : S_U1;
				end
				S_U1: begin
					na_q <= n_rd;
					wa_q <= w_rd;
					state_q <= S_U2;
				end
				S_U2: begin
					win_q <= win;
					nwn_q.parent <= win;
					nwn_q.size <= na_q.size + n_rd.size;
					nwn_q.min_idx <= (n_rd.min_idx < na_q.min_idx) ? n_rd.min_idx : na_q.min_idx;
					nwn_q.max_idx <= (n_rd.max_idx > na_q.max_idx) ? n_rd.max_idx : na_q.max_idx;
					nwt_q <= wa_q + w_rd;
					state_q <= S_U3;
				end
				S_U3: begin
					ra_q <= win_q;
					rb_q <= win_q;
					state_q <= S_REP;
				end
				S_REP: begin
					state_q <= S_REP2;
				end
				S_REP2: begin
					// Read data holds while the previous result still waits.
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						result_q.root_of_a <= NODE_FIELD_W'(ra_q);
						result_q.same_set <= ra_q == rb_q;
						result_q.set_size <= SIZE_FIELD_W'(n_rd.size);
						result_q.set_min <= NODE_FIELD_W'(n_rd.min_idx);
						result_q.set_max <= NODE_FIELD_W'(n_rd.max_idx);
						result_q.set_weight <= w_rd;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/wuf_checker.sv
// Port-level checker for the weighted union-find core, with its bind.
module wuf_checker import wuf_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A stalled result beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// One item at a time: the input stalls right after an accepted beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input accepted while an item is in work");

	// The reported root lies within its set's index range.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.set_min <= result.root_of_a && result.root_of_a <= result.set_max)
		else $error("root outside set range");

	// A set holds at least one node and no more than its index span.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.set_size != 11'd0 &&
			result.set_size <= 11'(result.set_max - result.set_min) + 11'd1)
		else $error("set size inconsistent with its range");

endmodule

bind weighted_union_find_core wuf_checker u_wuf_checker (.*);
